/* rtl/rlpe_pkg.sv */
// ----------------------------------------------------------------------------
// rlpe_pkg: shared types and constants for the RGB LED pulse encoder
// Register map, reset values, queue entry and descriptor layouts, and the
// divide-by-25 helper used by the front end.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  // Bits per LED and the descriptor index of the group pause
  localparam int BitsPerLed = 24;
  localparam int IdxW       = 5;
  localparam logic [IdxW-1:0] LastBitIdx = IdxW'(BitsPerLed - 1);
  localparam logic [IdxW-1:0] PauseIdx   = IdxW'(BitsPerLed);

  // x / 25 == (x * 41) >> 10 for every 8-bit x
  localparam int ScaleMul   = 41;
  localparam int ScaleShift = 10;

  // Front-to-back job queue
  localparam int QDepth = 2;
  localparam int QAw    = 1;

  // Configuration port
  localparam int RegAw = 5;

  typedef enum logic [2:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3,
    REG_PAUSE     = 3'd4
  } rlpe_reg_e;

  localparam logic [7:0]  OneHighRst  = 8'd7;
  localparam logic [7:0]  OneLowRst   = 8'd4;
  localparam logic [7:0]  ZeroHighRst = 8'd3;
  localparam logic [7:0]  ZeroLowRst  = 8'd8;
  localparam logic [31:0] PauseRst    = 32'd16800000;

  typedef struct packed {
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [31:0] pause;
  } rlpe_cfg_t;

  // One LED worth of work: scaled GRB word plus group-end flag
  typedef struct packed {
    logic [BitsPerLed-1:0] word;
    logic                  group_end;
  } rlpe_job_t;

  typedef struct packed {
    logic [7:0]  high_time;
    logic [31:0] low_time;
    logic        is_pause;
    logic        last;
  } rlpe_desc_t;

  // Scale one channel byte to 0..10
  function automatic logic [7:0] scale25(input logic [7:0] x);
    logic [13:0] p;
    p = {6'd0, x} * 14'(ScaleMul);
    return {4'd0, p[13:ScaleShift]};
  endfunction

endpackage

/* rtl/rlpe_regs.sv */
// ----------------------------------------------------------------------------
// rlpe_regs: configuration registers
// APB-style write/read of the pulse timing and pause length registers.
// ----------------------------------------------------------------------------
module rlpe_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rlpe_pkg::RegAw-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output rlpe_pkg::rlpe_cfg_t       cfg
);
  import rlpe_pkg::*;

  rlpe_reg_e sel;
  logic      wr_en;

  assign sel    = rlpe_reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high  <= OneHighRst;
      cfg.one_low   <= OneLowRst;
      cfg.zero_high <= ZeroHighRst;
      cfg.zero_low  <= ZeroLowRst;
      cfg.pause     <= PauseRst;
    end else if (wr_en) begin
      case (sel)
        REG_ONE_HIGH:  cfg.one_high  <= pwdata[7:0];
        REG_ONE_LOW:   cfg.one_low   <= pwdata[7:0];
        REG_ZERO_HIGH: cfg.zero_high <= pwdata[7:0];
        REG_ZERO_LOW:  cfg.zero_low  <= pwdata[7:0];
        REG_PAUSE:     cfg.pause     <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_ONE_HIGH:  prdata = {24'd0, cfg.one_high};
      REG_ONE_LOW:   prdata = {24'd0, cfg.one_low};
      REG_ZERO_HIGH: prdata = {24'd0, cfg.zero_high};
      REG_ZERO_LOW:  prdata = {24'd0, cfg.zero_low};
      REG_PAUSE:     prdata = cfg.pause;
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/rlpe_front.sv */
// ----------------------------------------------------------------------------
// rlpe_front: colour intake
// Scales each channel by 1/25, packs GRB order and tags the group end.
// ----------------------------------------------------------------------------
module rlpe_front #(
  parameter int LEDS_PER_GROUP = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic                 q_full,
  output logic                 q_push,
  output rlpe_pkg::rlpe_job_t  job
);
  import rlpe_pkg::*;

  localparam int PosW = (LEDS_PER_GROUP > 1) ? $clog2(LEDS_PER_GROUP) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(LEDS_PER_GROUP - 1);

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic            group_end;

  assign q_push    = push && !q_full;
  assign group_end = (pos == PosLast);

  // scaled word, green first
  assign job.word      = {scale25(green), scale25(red), scale25(blue)};
  assign job.group_end = group_end;

  // LED position within the group
  always_comb begin
    pos_next = pos;
    if (q_push) begin
      pos_next = group_end ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

/* rtl/rlpe_queue.sv */
// ----------------------------------------------------------------------------
// rlpe_queue: job queue
// Two-entry FIFO between the intake and the serializer.
// ----------------------------------------------------------------------------
module rlpe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  rlpe_pkg::rlpe_job_t wdata,
  output logic                full,
  input  logic                rd,
  output logic                valid,
  output rlpe_pkg::rlpe_job_t rdata
);
  import rlpe_pkg::*;

  rlpe_job_t       mem [QDepth];
  logic [QAw-1:0]  wptr;
  logic [QAw-1:0]  rptr;
  logic [QAw:0]    count;

  assign full  = (count == (QAw+1)'(QDepth));
  assign valid = (count != '0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/rlpe_back.sv */
// ----------------------------------------------------------------------------
// rlpe_back: descriptor serializer
// Walks the 24 bits of a job MSB first, adds the group pause, and holds
// each descriptor in an output register until it is popped.
// ----------------------------------------------------------------------------
module rlpe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rlpe_pkg::rlpe_cfg_t  cfg,
  input  logic                 q_valid,
  input  rlpe_pkg::rlpe_job_t  q_job,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output rlpe_pkg::rlpe_desc_t desc
);
  import rlpe_pkg::*;

  logic                  active, active_next;
  logic [IdxW-1:0]       idx, idx_next;
  logic [BitsPerLed-1:0] word, word_next;
  logic                  ge, ge_next;
  logic                  ovalid, ovalid_next;
  rlpe_desc_t            cur;
  logic                  out_free;
  logic                  step;
  logic                  finishing;
  logic                  take;

  assign out_free  = !ovalid || pop;
  assign step      = active && out_free;
  assign finishing = active && ((idx == LastBitIdx && !ge) || idx == PauseIdx);
  assign take      = q_valid && (!active || (step && finishing));
  assign q_pop     = take;
  assign empty     = !ovalid;

  // descriptor for the current position
  always_comb begin
    if (idx == PauseIdx) begin
      cur.high_time = 8'd0;
      cur.low_time  = cfg.pause;
      cur.is_pause  = 1'b1;
      cur.last      = 1'b1;
    end else begin
      cur.high_time = word[BitsPerLed-1] ? cfg.one_high : cfg.zero_high;
      cur.low_time  = {24'd0, word[BitsPerLed-1] ? cfg.one_low : cfg.zero_low};
      cur.is_pause  = 1'b0;
      cur.last      = (idx == LastBitIdx) && !ge;
    end
  end

  // job sequencing
  always_comb begin
    active_next = active;
    idx_next    = idx;
    word_next   = word;
    ge_next     = ge;
    ovalid_next = out_free ? active : ovalid;
    if (take) begin
      active_next = 1'b1;
      idx_next    = '0;
      word_next   = q_job.word;
      ge_next     = q_job.group_end;
    end else if (step) begin
      word_next = word << 1;
      if (finishing) begin
        active_next = 1'b0;
        idx_next    = '0;
      end else begin
        idx_next = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      ovalid <= 1'b0;
    end else begin
      active <= active_next;
      idx    <= idx_next;
      ovalid <= ovalid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word <= word_next;
    ge   <= ge_next;
    if (step) begin
      desc <= cur;
    end
  end

  // a pause beat always closes the colour and never drives the line high
  a_pause_last: assert property (@(posedge clk) disable iff (rst)
    ovalid && desc.is_pause |-> desc.last && desc.high_time == 8'd0)
    else $error("pause beat without last or with high time");

  // the pause position is reached only for a group-end job
  a_pause_ge: assert property (@(posedge clk) disable iff (rst)
    active && idx == PauseIdx |-> ge)
    else $error("pause position reached outside a group end");

  // the bit counter never runs past the pause position
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= PauseIdx)
    else $error("bit counter out of range");

  // a stalled output beat is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !pop |=> ovalid && $stable(desc))
    else $error("pending descriptor lost");

endmodule

/* rtl/rgb_led_pulse_encoder.sv */
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder: LED colour to pulse descriptor encoder
// A pushed colour passes the job queue, the serializer's job registers and
// the output register, which shows each descriptor. A colour gives 24
// descriptors, 25 at a group end, one per cycle while jobs wait and pop
// frees the output; a two-entry job queue keeps intake running.
// Reset: synchronous rst empties the queue and output, clears the group
// position and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder #(
  parameter int LEDS_PER_GROUP = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // colour intake
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  // descriptor output
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 high_time,
  output logic [31:0]                low_time,
  output logic                       is_pause,
  output logic                       last,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rlpe_pkg::RegAw-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rlpe_pkg::*;

  rlpe_cfg_t  cfg;
  rlpe_job_t  f_job;
  rlpe_job_t  q_job;
  rlpe_desc_t desc;
  logic       f_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign full      = q_full;
  assign high_time = desc.high_time;
  assign low_time  = desc.low_time;
  assign is_pause  = desc.is_pause;
  assign last      = desc.last;

  rlpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlpe_front #(
    .LEDS_PER_GROUP (LEDS_PER_GROUP)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .red    (red),
    .green  (green),
    .blue   (blue),
    .q_full (q_full),
    .q_push (f_push),
    .job    (f_job)
  );

  rlpe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_push),
    .wdata (f_job),
    .full  (q_full),
    .rd    (q_pop),
    .valid (q_valid),
    .rdata (q_job)
  );

  rlpe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .desc    (desc)
  );

endmodule

/* tb/sv/rgb_led_pulse_encoder_tb.sv */
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_tb: self-checking bench for the RGB LED pulse encoder
// Colours go in through a push/full driver fed from a queue of pending items.
// Descriptors come out through a pop/empty monitor that checks every field
// against a predictor of the encoder. Both sides idle in random bursts. The
// timing registers are written over APB between phases and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_led_pulse_encoder_tb;
  import rlpe_pkg::*;

  localparam int LedsPerGroup = 8;
  localparam int MaxPrinted   = 30;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // Clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  high_time;
  logic [31:0] low_time;
  logic        is_pause;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [RegAw-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench state
  colour_t    pending_colours[$];
  rlpe_desc_t expected_descs[$];
  rlpe_cfg_t  timing = '{OneHighRst, OneLowRst, ZeroHighRst, ZeroLowRst, PauseRst};
  int         group_pos = 0;
  bit         calm = 1'b0;
  int         push_gap = 0;
  int         pop_gap = 0;
  int         errors = 0;
  int         colours_sent = 0;
  int         descs_seen = 0;
  int         pauses_seen = 0;
  int         settings_used = 1;

  rlpe_reg_e all_regs[5] = '{REG_ONE_HIGH, REG_ONE_LOW, REG_ZERO_HIGH, REG_ZERO_LOW,
                             REG_PAUSE};

  colour_t directed[16] = '{
    24'h000000, 24'hFFFFFF, 24'h181818, 24'h191919,
    24'hF9FA00, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'h7D324B, 24'hE0E1E2, 24'h31644A, 24'hAEAFC7,
    24'hC8F9FA, 24'h191800, 24'h00FA18, 24'hFAFAFA
  };

  rgb_led_pulse_encoder #(
    .LEDS_PER_GROUP(LedsPerGroup)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .empty     (empty),
    .pop       (pop),
    .high_time (high_time),
    .low_time  (low_time),
    .is_pause  (is_pause),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One line per mismatch, printing capped
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("desc %0d %s got %0h want %0h", descs_seen, name, got, want));
  endtask

  // Expected descriptors for one colour: 24 bits in GRB order, MSB first,
  // then a pause when this LED closes its group
  function automatic void encode_colour(input colour_t c);
    logic [23:0] grb;
    logic        group_end;
    logic        bit_val;
    rlpe_desc_t  d;
    grb = {8'(c.green / 25), 8'(c.red / 25), 8'(c.blue / 25)};
    group_end = (group_pos + 1 >= LedsPerGroup);
    for (int i = 0; i < 24; i++) begin
      bit_val = grb[23-i];
      d.high_time = bit_val ? timing.one_high : timing.zero_high;
      d.low_time  = {24'd0, bit_val ? timing.one_low : timing.zero_low};
      d.is_pause  = 1'b0;
      d.last      = (i == 23) && !group_end;
      expected_descs.push_back(d);
    end
    if (group_end) begin
      d.high_time = '0;
      d.low_time  = timing.pause;
      d.is_pause  = 1'b1;
      d.last      = 1'b1;
      expected_descs.push_back(d);
      group_pos = 0;
    end else begin
      group_pos++;
    end
  endfunction

  function automatic logic [31:0] reg_of(input rlpe_cfg_t cfg, input rlpe_reg_e idx);
    case (idx)
      REG_ONE_HIGH:  return {24'd0, cfg.one_high};
      REG_ONE_LOW:   return {24'd0, cfg.one_low};
      REG_ZERO_HIGH: return {24'd0, cfg.zero_high};
      REG_ZERO_LOW:  return {24'd0, cfg.zero_low};
      default:       return cfg.pause;
    endcase
  endfunction

  // APB write: setup then access, done when pready is seen
  task automatic write_reg(input rlpe_reg_e idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read, prdata sampled mid-cycle during the access phase
  task automatic check_reg(input rlpe_reg_e idx, input logic [31:0] want);
    logic [31:0] got;
    logic        ready;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      got   = prdata;
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("reg %s read %0h want %0h", idx.name(), got, want));
  endtask

  task automatic load_timing(input rlpe_cfg_t cfg);
    foreach (all_regs[i]) write_reg(all_regs[i], reg_of(cfg, all_regs[i]));
    timing = cfg;
    settings_used++;
    foreach (all_regs[i]) check_reg(all_regs[i], reg_of(timing, all_regs[i]));
  endtask

  function automatic rlpe_cfg_t rand_timing();
    rlpe_cfg_t cfg;
    cfg.one_high  = 8'($urandom);
    cfg.one_low   = 8'($urandom);
    cfg.zero_high = 8'($urandom);
    cfg.zero_low  = 8'($urandom);
    case ($urandom_range(0, 2))
      0:       cfg.pause = $urandom_range(0, 255);
      1:       cfg.pause = $urandom;
      default: cfg.pause = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
    return cfg;
  endfunction

  // Mostly uniform bytes, some right at a step of the divide by 25
  function automatic logic [7:0] rand_channel();
    int k;
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 10) * 25;
      return 8'(k - $urandom_range(0, 1));
    end
    return 8'($urandom);
  endfunction

  task automatic queue_random_colours(input int count);
    colour_t c;
    @(negedge clk);
    repeat (count) begin
      c.red   = rand_channel();
      c.green = rand_channel();
      c.blue  = rand_channel();
      pending_colours.push_back(c);
    end
  endtask

  task automatic wait_drained();
    while (pending_colours.size() != 0 || expected_descs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Intake driver: one beat per accepted colour, random idle bursts
  always @(posedge clk) begin
    colour_t nxt;
    logic    drive;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_colour('{red, green, blue});
        void'(pending_colours.pop_front());
        colours_sent++;
      end
      drive = 1'b0;
      if (push_gap > 0) begin
        push_gap--;
      end else if (pending_colours.size() != 0) begin
        if (!calm && $urandom_range(0, 5) == 0) push_gap = $urandom_range(0, 10);
        else drive = 1'b1;
      end
      push <= drive;
      if (drive) begin
        nxt = pending_colours[0];
        red   <= nxt.red;
        green <= nxt.green;
        blue  <= nxt.blue;
      end
    end
  end

  // Descriptor monitor: check each popped beat against the oldest expectation
  always @(posedge clk) begin
    rlpe_desc_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_descs.size() == 0) begin
          report_mismatch($sformatf("desc %0d arrived with nothing expected", descs_seen));
        end else begin
          want = expected_descs.pop_front();
          check_field("high_time", {24'd0, high_time}, {24'd0, want.high_time});
          check_field("low_time", low_time, want.low_time);
          check_field("is_pause", {31'd0, is_pause}, {31'd0, want.is_pause});
          check_field("last", {31'd0, last}, {31'd0, want.last});
        end
        if (is_pause) pauses_seen++;
        descs_seen++;
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop_gap = $urandom_range(0, 10);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus phases
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values, then directed colours at default timing
    foreach (all_regs[i]) check_reg(all_regs[i], reg_of(timing, all_regs[i]));
    @(negedge clk);
    foreach (directed[i]) pending_colours.push_back(directed[i]);
    wait_drained();

    // All-zero timing, including a zero-length pause
    load_timing('{8'd0, 8'd0, 8'd0, 8'd0, 32'd0});
    queue_random_colours(20);
    wait_drained();

    // All-ones timing
    load_timing('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
    queue_random_colours(20);
    wait_drained();

    repeat (4) begin
      load_timing(rand_timing());
      queue_random_colours(28);
      wait_drained();
    end

    // Closing stretch at full rate
    calm = 1'b1;
    load_timing(rand_timing());
    queue_random_colours(28);
    wait_drained();
    repeat (30) @(posedge clk);

    $display("Encoded %0d colours into %0d descriptors (%0d group pauses)",
             colours_sent, descs_seen, pauses_seen);
    $display("Timing settings used: %0d, mismatches: %0d", settings_used, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Timed out with %0d colours pending, %0d descriptors expected",
             pending_colours.size(), expected_descs.size());
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/rlpe_pkg.sv
rtl/rlpe_regs.sv
rtl/rlpe_front.sv
rtl/rlpe_queue.sv
rtl/rlpe_back.sv
rtl/rgb_led_pulse_encoder.sv
tb/sv/rgb_led_pulse_encoder_tb.sv
